// ===== rtl/trcl_pkg.sv =====
// Shared types and constants for the traction current ramp limiter.
`default_nettype none

package trcl_pkg;

  localparam int CUR_W     = 18;
  localparam int RATE_W    = 20;
  localparam int RPM_W     = 17;
  localparam int Q12_W     = 13;
  localparam int DT_W      = 16;
  localparam int STEP_W    = 27;
  localparam int DIV_CNT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int RECIP_W   = 24;

  localparam logic [Q12_W-1:0]     SCALE_ONE    = 13'd4096;
  localparam logic [DT_W-1:0]      DEFAULT_DT   = 16'd10;
  localparam logic [DT_W-1:0]      MAX_DT       = 16'hFFFF;
  localparam logic [CUR_W-1:0]     INTERLOCK_MA = 18'd10;
  localparam logic [RPM_W-1:0]     MS_PER_S     = 17'd1000;
  // Rounded-up 2^30 / 125, exact for every dividend below 2^23.
  localparam logic [RECIP_W-1:0]   RECIP_125    = 24'd8589935;
  localparam logic [DIV_CNT_W-1:0] TAPER_STEPS  = 5'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DRIVE   = 3'd0,
    CFG_MAX_BRAKE   = 3'd1,
    CFG_DRIVE_RATE  = 3'd2,
    CFG_BRAKE_RATE  = 3'd3,
    CFG_LIMIT_RPM   = 3'd4,
    CFG_START_RPM   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAPER,
    S_TDIV,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DFOLD,
    S_DRECIP,
    S_DSTEP,
    S_BFOLD,
    S_BRECIP,
    S_BSTEP,
    S_RAMP,
    S_LOCK
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/traction_current_ramp_limiter.sv =====
// Top level of the traction current ramp limiter with its sequencer and shared datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------------
//   cfg     | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//   in      | in        | in_valid, in_ready   | enabled, emergency_stop, throttle, ...
//   out     | out       | out_valid, out_ready | speed_scale, targets, ramped currents
//
// A transaction on the input channel is worked on by the sequencer, through the bit-serial
// taper divider of 12 steps when the speed taper divides, and through a fold, a reciprocal
// multiply and a step state per ramp step for a division by 1000 on the one shared multiplier.
// in_ready rises again the cycle after the result is registered. A result that has not
// been taken holds the next one in its final state.
// Reset is synchronous and clears the levels, the last tick and all configuration registers.
`default_nettype none

module traction_current_ramp_limiter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [trcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [trcl_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          enabled,
  input  wire logic                          emergency_stop,
  input  wire logic signed [15:0]            throttle,
  input  wire logic signed [15:0]            brake_demand,
  input  wire logic                          telemetry_valid,
  input  wire logic signed [17:0]            motor_rpm,
  input  wire logic [31:0]                   now_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [trcl_pkg::Q12_W-1:0]         speed_scale,
  output logic [trcl_pkg::CUR_W-1:0]         drive_target_ma,
  output logic [trcl_pkg::CUR_W-1:0]         brake_target_ma,
  output logic [trcl_pkg::CUR_W-1:0]         drive_current_ma,
  output logic [trcl_pkg::CUR_W-1:0]         brake_current_ma
);

  import trcl_pkg::*;

  function automatic logic [Q12_W-1:0] clamp_q12(input logic signed [15:0] v);
    logic [Q12_W-1:0] r;
    if (v[15]) begin
      r = '0;
    end else if (v > $signed({3'b000, SCALE_ONE})) begin
      r = SCALE_ONE;
    end else begin
      r = v[Q12_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CUR_W-1:0] ramp_level(input logic [CUR_W-1:0] level,
                                                   input logic [CUR_W-1:0] target,
                                                   input logic [STEP_W-1:0] step);
    logic [STEP_W:0]  sum;
    logic [CUR_W-1:0] diff;
    logic [CUR_W-1:0] r;
    sum  = {{(STEP_W + 1 - CUR_W){1'b0}}, level} + {1'b0, step};
    diff = level - target;
    if (level < target) begin
      r = (sum > {{(STEP_W + 1 - CUR_W){1'b0}}, target}) ? target : sum[CUR_W-1:0];
    end else if (level > target) begin
      r = (step >= {{(STEP_W - CUR_W){1'b0}}, diff}) ? target : level - step[CUR_W-1:0];
    end else begin
      r = level;
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [CUR_W-1:0]  max_drive, max_brake;
  logic [RATE_W-1:0] drive_rate, brake_rate;
  logic [RPM_W-1:0]  limit_rpm, start_rpm;

  logic [CUR_W-1:0] drive_level, brake_level;
  logic [31:0]      last_tick;

  logic             item_active;
  logic [Q12_W-1:0] item_thr, item_brk;
  logic             item_tlm;
  logic [17:0]      item_rpm;
  logic [DT_W-1:0]  dt;

  logic [Q12_W-1:0]  scale;
  logic [CUR_W-1:0]  drive_t, brake_t;
  logic [STEP_W-1:0] dstep, bstep;
  logic [CUR_W-1:0]  drive_ramp, brake_ramp;

  logic [30:0]        mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [46:0]        mul_p, mul_full;

  logic [17:0]       fold_a;
  logic [25:0]       fold_z;
  logic [22:0]       fold_w;
  logic [STEP_W-1:0] fold_hi, step_sum;

  logic [RPM_W-1:0]     div_rem, div_den;
  logic [Q12_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [RPM_W:0]       div_t, div_diff;
  logic                 div_ge;

  logic        in_fire, out_free, div_last, brk_nz;
  logic [31:0] elapsed;
  logic [DT_W-1:0] dt_new;
  logic [17:0] mag;
  logic [CUR_W-1:0] lock_drive, lock_brake;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign div_last  = (div_cnt == {{(DIV_CNT_W - 1){1'b0}}, 1'b1});
  assign brk_nz    = (item_brk != '0);

  assign elapsed = now_ms - last_tick;
  always_comb begin
    if (last_tick != 32'd0 && now_ms > last_tick) begin
      dt_new = (elapsed[31:DT_W] != '0) ? MAX_DT : elapsed[DT_W-1:0];
    end else begin
      dt_new = DEFAULT_DT;
    end
  end

  assign mag = item_rpm[17] ? (~item_rpm + 18'd1) : item_rpm;

  assign div_t    = {div_rem, 1'b0};
  assign div_diff = div_t - {1'b0, div_den};
  assign div_ge   = (div_t >= {1'b0, div_den});

  // Since 2^18 = 262 * 1000 + 144, the upper part of the product folds into the lower one.
  assign fold_a   = mul_p[35:18];
  assign fold_z   = {1'b0, fold_a, 7'd0} + {4'd0, fold_a, 4'd0} + {8'd0, mul_p[17:0]};
  assign step_sum = fold_hi + {10'd0, mul_p[46:30]};

  assign mul_full = {16'd0, mul_a} * {23'd0, mul_b};

  always_comb begin
    lock_drive = (brake_ramp > INTERLOCK_MA) ? '0 : drive_ramp;
    lock_brake = (lock_drive > INTERLOCK_MA) ? '0 : brake_ramp;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL1: begin
        mul_a = {13'd0, (brk_nz ? max_brake : max_drive)};
        mul_b = {11'd0, (brk_nz ? item_brk : item_thr)};
      end
      S_MUL2: begin
        mul_a = mul_p[30:0];
        mul_b = {11'd0, scale};
      end
      S_MUL3: begin
        mul_a = {11'd0, drive_rate};
        mul_b = {8'd0, dt};
      end
      S_DRECIP, S_BRECIP: begin
        mul_a = {8'd0, fold_w};
        mul_b = RECIP_125;
      end
      S_DSTEP: begin
        mul_a = {11'd0, brake_rate};
        mul_b = {8'd0, dt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_TAPER;
      end
      S_TAPER: begin
        if (!item_tlm || limit_rpm == '0 || start_rpm == '0 ||
            mag <= {1'b0, start_rpm} || mag >= {1'b0, limit_rpm}) begin
          state_next = S_MUL1;
        end else begin
          state_next = S_TDIV;
        end
      end
      S_TDIV:   if (div_last) state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_MUL3;
      S_MUL3:   state_next = S_DFOLD;
      S_DFOLD:  state_next = S_DRECIP;
      S_DRECIP: state_next = S_DSTEP;
      S_DSTEP:  state_next = S_BFOLD;
      S_BFOLD:  state_next = S_BRECIP;
      S_BRECIP: state_next = S_BSTEP;
      S_BSTEP:  state_next = S_RAMP;
      S_RAMP:   state_next = S_LOCK;
      S_LOCK:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_drive  <= '0;
      max_brake  <= '0;
      drive_rate <= '0;
      brake_rate <= '0;
      limit_rpm  <= '0;
      start_rpm  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_DRIVE:  max_drive  <= cfg_data[CUR_W-1:0];
        CFG_MAX_BRAKE:  max_brake  <= cfg_data[CUR_W-1:0];
        CFG_DRIVE_RATE: drive_rate <= cfg_data[RATE_W-1:0];
        CFG_BRAKE_RATE: brake_rate <= cfg_data[RATE_W-1:0];
        CFG_LIMIT_RPM:  limit_rpm  <= cfg_data[RPM_W-1:0];
        CFG_START_RPM:  start_rpm  <= cfg_data[RPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick   <= '0;
      drive_level <= '0;
      brake_level <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_fire) last_tick <= now_ms;
      if (state == S_LOCK && out_free) begin
        drive_level <= lock_drive;
        brake_level <= lock_brake;
        out_valid   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_active <= enabled && !emergency_stop;
      item_thr    <= clamp_q12(throttle);
      item_brk    <= clamp_q12(brake_demand);
      item_tlm    <= telemetry_valid;
      item_rpm    <= motor_rpm;
      dt          <= dt_new;
    end

    unique case (state)
      S_TAPER: begin
        div_cnt <= TAPER_STEPS;
        div_rem <= limit_rpm - mag[RPM_W-1:0];
        div_den <= limit_rpm - start_rpm;
        if (!item_tlm || limit_rpm == '0 || start_rpm == '0 ||
            mag <= {1'b0, start_rpm}) begin
          div_quo <= SCALE_ONE;
        end else begin
          div_quo <= '0;
        end
      end
      S_TDIV: begin
        div_rem <= div_ge ? div_diff[RPM_W-1:0] : div_t[RPM_W-1:0];
        div_quo <= {div_quo[Q12_W-2:0], div_ge};
        div_cnt <= div_cnt - {{(DIV_CNT_W - 1){1'b0}}, 1'b1};
      end
      S_MUL1: begin
        scale <= div_quo;
        mul_p <= mul_full;
      end
      S_MUL2: begin
        brake_t <= (item_active && brk_nz) ? mul_p[29:12] : '0;
        mul_p   <= mul_full;
      end
      S_MUL3: begin
        drive_t <= (item_active && !brk_nz) ? mul_p[41:24] : '0;
        mul_p   <= mul_full;
      end
      S_DFOLD, S_BFOLD: begin
        fold_w  <= fold_z[25:3];
        fold_hi <= {1'b0, fold_a, 8'd0} + {7'd0, fold_a, 2'd0} + {8'd0, fold_a, 1'b0};
      end
      S_DRECIP, S_BRECIP: begin
        mul_p <= mul_full;
      end
      S_DSTEP: begin
        dstep <= step_sum;
        mul_p <= mul_full;
      end
      S_BSTEP: begin
        bstep <= step_sum;
      end
      S_RAMP: begin
        drive_ramp <= ramp_level(drive_level, drive_t, dstep);
        brake_ramp <= ramp_level(brake_level, brake_t, bstep);
      end
      S_LOCK: begin
        if (out_free) begin
          speed_scale      <= scale;
          drive_target_ma  <= drive_t;
          brake_target_ma  <= brake_t;
          drive_current_ma <= lock_drive;
          brake_current_ma <= lock_brake;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_current_interlock: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_current_ma > INTERLOCK_MA && brake_current_ma > INTERLOCK_MA))
    else $error("drive and brake currents both above the interlock threshold");

  a_target_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_target_ma == '0 || brake_target_ma == '0))
    else $error("drive and brake targets both nonzero");

  a_scale_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_scale <= SCALE_ONE)
    else $error("speed scale above unity");
`endif

endmodule

`default_nettype wire

// ===== test/tb_traction_current_ramp_limiter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the traction current ramp limiter with its own current predictor.
module tb_traction_current_ramp_limiter;
  import trcl_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int NUM_REGS         = int'(CFG_START_RPM) + 1;
  localparam int RANDOM_PER_PHASE = 155;
  localparam int NUM_PHASES       = 6;
  localparam int DRAIN_CYCLES     = 80;
  localparam int HOLD_CYCLES      = 500;
  localparam int REPORT_LIMIT     = 10;

  typedef struct {
    bit        enabled;
    bit        emergency_stop;
    bit [15:0] throttle;
    bit [15:0] brake_demand;
    bit        telemetry_valid;
    bit [17:0] motor_rpm;
    bit [31:0] now_ms;
  } tick_t;

  typedef struct {
    bit [Q12_W-1:0] speed_scale;
    bit [CUR_W-1:0] drive_target;
    bit [CUR_W-1:0] brake_target;
    bit [CUR_W-1:0] drive_current;
    bit [CUR_W-1:0] brake_current;
  } command_t;

  class ramp_scoreboard;
    bit [CUR_W-1:0]  max_drive;
    bit [CUR_W-1:0]  max_brake;
    bit [RATE_W-1:0] drive_rate;
    bit [RATE_W-1:0] brake_rate;
    bit [RPM_W-1:0]  limit_rpm;
    bit [RPM_W-1:0]  start_rpm;
    bit [CUR_W-1:0]  drive_level;
    bit [CUR_W-1:0]  brake_level;
    bit [31:0]       last_tick;
    command_t        expected_cmds[$];
    int              errors;

    function void set_reg(cfg_idx_t idx, bit [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_MAX_DRIVE:  max_drive = data[CUR_W-1:0];
        CFG_MAX_BRAKE:  max_brake = data[CUR_W-1:0];
        CFG_DRIVE_RATE: drive_rate = data[RATE_W-1:0];
        CFG_BRAKE_RATE: brake_rate = data[RATE_W-1:0];
        CFG_LIMIT_RPM:  limit_rpm = data[RPM_W-1:0];
        CFG_START_RPM:  start_rpm = data[RPM_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function bit [Q12_W-1:0] clamp_q12(bit [15:0] raw);
      if (raw[15]) return '0;
      if (raw > 16'(SCALE_ONE)) return SCALE_ONE;
      return raw[Q12_W-1:0];
    endfunction

    function bit [Q12_W-1:0] taper(bit tv, bit [17:0] rpm);
      bit [17:0] mag;
      longint unsigned num;
      longint unsigned den;
      if (!tv || limit_rpm == 0 || start_rpm == 0) return SCALE_ONE;
      mag = rpm[17] ? (~rpm + 18'd1) : rpm;
      if (mag <= 18'(start_rpm)) return SCALE_ONE;
      if (mag >= 18'(limit_rpm)) return '0;
      num = (limit_rpm - mag) * SCALE_ONE;
      den = limit_rpm - start_rpm;
      return Q12_W'(num / den);
    endfunction

    function bit [CUR_W-1:0] slew(bit [CUR_W-1:0] level, bit [CUR_W-1:0] target,
                                  longint unsigned stp);
      longint unsigned sum;
      if (level < target) begin
        sum = level + stp;
        return (sum > target) ? target : CUR_W'(sum);
      end
      if (level > target) begin
        return (stp >= 64'(level - target)) ? target : CUR_W'(level - stp);
      end
      return level;
    endfunction

    function command_t predict_command(tick_t t);
      command_t c;
      bit [Q12_W-1:0] thr;
      bit [Q12_W-1:0] brk;
      bit [31:0] dt;
      longint unsigned prod;
      longint unsigned dstep;
      longint unsigned bstep;
      dt = DEFAULT_DT;
      if (last_tick != 0 && t.now_ms > last_tick) begin
        dt = (t.now_ms - last_tick > MAX_DT) ? MAX_DT : t.now_ms - last_tick;
      end
      last_tick = t.now_ms;
      thr = clamp_q12(t.throttle);
      brk = clamp_q12(t.brake_demand);
      c.speed_scale = taper(t.telemetry_valid, t.motor_rpm);
      c.drive_target = '0;
      c.brake_target = '0;
      if (t.enabled && !t.emergency_stop) begin
        if (brk != 0) begin
          prod = brk * max_brake;
          c.brake_target = CUR_W'(prod >> 12);
        end else begin
          prod = thr * max_drive * c.speed_scale;
          c.drive_target = CUR_W'(prod >> 24);
        end
      end
      dstep = drive_rate * dt / MS_PER_S;
      bstep = brake_rate * dt / MS_PER_S;
      drive_level = slew(drive_level, c.drive_target, dstep);
      brake_level = slew(brake_level, c.brake_target, bstep);
      if (brake_level > INTERLOCK_MA) drive_level = '0;
      if (drive_level > INTERLOCK_MA) brake_level = '0;
      c.drive_current = drive_level;
      c.brake_current = brake_level;
      return c;
    endfunction

    function void note_tick(tick_t t);
      expected_cmds.push_back(predict_command(t));
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Unexpected result: scale %0d drive %0d/%0d brake %0d/%0d",
                   got.speed_scale, got.drive_target, got.drive_current,
                   got.brake_target, got.brake_current);
        end
        return;
      end
      want = expected_cmds.pop_front();
      if (got.speed_scale != want.speed_scale || got.drive_target != want.drive_target ||
          got.brake_target != want.brake_target || got.drive_current != want.drive_current ||
          got.brake_current != want.brake_current) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Mismatch: expected scale %0d drive %0d/%0d brake %0d/%0d",
                   want.speed_scale, want.drive_target, want.drive_current,
                   want.brake_target, want.brake_current);
          $display("          actual   scale %0d drive %0d/%0d brake %0d/%0d",
                   got.speed_scale, got.drive_target, got.drive_current,
                   got.brake_target, got.brake_current);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_MAX_DRIVE;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  enabled = 1'b0;
  logic                  emergency_stop = 1'b0;
  logic signed [15:0]    throttle = '0;
  logic signed [15:0]    brake_demand = '0;
  logic                  telemetry_valid = 1'b0;
  logic signed [17:0]    motor_rpm = '0;
  logic [31:0]           now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [Q12_W-1:0]      speed_scale;
  logic [CUR_W-1:0]      drive_target_ma;
  logic [CUR_W-1:0]      brake_target_ma;
  logic [CUR_W-1:0]      drive_current_ma;
  logic [CUR_W-1:0]      brake_current_ma;

  ramp_scoreboard sb;
  int        cycles = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        stall_asked = 0;
  int        stall_done = 0;
  int        hold_left = 0;
  bit [31:0] prev_now = '0;

  traction_current_ramp_limiter dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .enabled(enabled),
    .emergency_stop(emergency_stop),
    .throttle(throttle),
    .brake_demand(brake_demand),
    .telemetry_valid(telemetry_valid),
    .motor_rpm(motor_rpm),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .speed_scale(speed_scale),
    .drive_target_ma(drive_target_ma),
    .brake_target_ma(brake_target_ma),
    .drive_current_ma(drive_current_ma),
    .brake_current_ma(brake_current_ma)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_asked != stall_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      stall_done <= stall_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    command_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.speed_scale = speed_scale;
      seen.drive_target = drive_target_ma;
      seen.brake_target = brake_target_ma;
      seen.drive_current = drive_current_ma;
      seen.brake_current = brake_current_ma;
      sb.check_command(seen);
    end
  end

  function automatic tick_t mk_tick(bit en, bit es, int thr, int brk, bit tv, int rpm,
                                    bit [31:0] stamp);
    tick_t t;
    t.enabled = en;
    t.emergency_stop = es;
    t.throttle = 16'(thr);
    t.brake_demand = 16'(brk);
    t.telemetry_valid = tv;
    t.motor_rpm = 18'(rpm);
    t.now_ms = stamp;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int pick;
    int span;
    bit [17:0] mag;
    span = (sb.limit_rpm > sb.start_rpm) ? int'(sb.limit_rpm) : int'(sb.start_rpm);
    if (span < 1000) span = 1000;
    t.enabled = ($urandom_range(99) < 90);
    t.emergency_stop = ($urandom_range(99) < 5);
    pick = $urandom_range(99);
    if (pick < 70) t.throttle = 16'($urandom_range(0, 4096));
    else if (pick < 80) t.throttle = 16'(SCALE_ONE);
    else t.throttle = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) t.brake_demand = '0;
    else if (pick < 85) t.brake_demand = 16'($urandom_range(1, 4096));
    else t.brake_demand = 16'($urandom);
    t.telemetry_valid = ($urandom_range(99) < 85);
    if ($urandom_range(99) < 75) begin
      mag = 18'($urandom_range(0, span + span / 4));
      t.motor_rpm = $urandom_range(1) ? (~mag + 18'd1) : mag;
    end else begin
      t.motor_rpm = 18'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 80) t.now_ms = prev_now + $urandom_range(1, 30);
    else if (pick < 85) t.now_ms = '0;
    else if (pick < 90) t.now_ms = prev_now;
    else if (pick < 94) t.now_ms = prev_now - $urandom_range(1, 50);
    else if (pick < 97) t.now_ms = prev_now + $urandom_range(1000, 200000);
    else t.now_ms = $urandom;
    return t;
  endfunction

  task automatic offer_tick(input tick_t t);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    enabled <= t.enabled;
    emergency_stop <= t.emergency_stop;
    throttle <= t.throttle;
    brake_demand <= t.brake_demand;
    telemetry_valid <= t.telemetry_valid;
    motor_rpm <= t.motor_rpm;
    now_ms <= t.now_ms;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
    prev_now = t.now_ms;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic load_settings(input bit [CFG_DAT_W-1:0] md, mb, dr, br, lim, st);
    bit [CFG_DAT_W-1:0] vals [NUM_REGS];
    vals = '{md, mb, dr, br, lim, st};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit with_hold);
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 40) stall_asked++;
      offer_tick(random_tick());
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = 21;
    rx_idle_pct = 85;

    offer_tick(mk_tick(1, 0, 4096, 0, 1, 50000, 0));
    offer_tick(mk_tick(1, 0, 2048, 2048, 0, -70000, 0));
    settle();
    load_settings(150000, 150000, 1000000, 1000000, 6000, 3000);
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 0, 0));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 0, 100));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 0, 100));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 0, 40));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 0, 200040));
    offer_tick(mk_tick(1, 0, -32768, 0, 1, 0, 200050));
    offer_tick(mk_tick(1, 0, 32767, 0, 1, 0, 200060));
    offer_tick(mk_tick(1, 0, 4095, 0, 1, 3000, 200070));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 6000, 200080));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, -4500, 200090));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, -131072, 200100));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 131071, 200110));
    offer_tick(mk_tick(1, 0, 4096, 0, 0, 5000, 200120));
    offer_tick(mk_tick(1, 0, 4096, 1, 1, 0, 200130));
    offer_tick(mk_tick(1, 0, 4096, 32767, 1, 0, 200140));
    offer_tick(mk_tick(1, 0, 2000, -32768, 1, 0, 200150));
    offer_tick(mk_tick(0, 0, 4096, 0, 1, 0, 200160));
    offer_tick(mk_tick(1, 1, 4096, 0, 1, 0, 200170));
    offer_tick(mk_tick(0, 1, 4096, 4096, 1, 0, 200180));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 0, 32'hFFFF_FFFF));
    settle();
    load_settings(150000, 150000, 50, 50, 2000, 3000);
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 2500, 0));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, 3500, 5));
    offer_tick(mk_tick(1, 0, 4096, 0, 1, -2500, 15));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p < 2) begin
        tx_idle_pct = 21;
        rx_idle_pct = 85;
      end else if (p < 4) begin
        tx_idle_pct = 85;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        1: load_settings(262143, 262143, 1048575, 1048575, 131071, 131071);
        2: load_settings($urandom_range(1000, 150000), $urandom_range(1000, 150000),
                         $urandom_range(0, 199), $urandom_range(0, 199),
                         $urandom_range(0, 100000), $urandom_range(0, 100000));
        3: load_settings($urandom_range(0, 262143), $urandom_range(0, 262143),
                         $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                         $urandom_range(0, 131071), $urandom_range(0, 131071));
        4: load_settings(0, 0, 0, 0, 0, 0);
        default: load_settings($urandom_range(20000, 150000), $urandom_range(20000, 150000),
                               $urandom_range(100000, 1000000),
                               $urandom_range(100000, 1000000),
                               $urandom_range(2000, 100000), $urandom_range(1000, 60000));
      endcase
      run_random(RANDOM_PER_PHASE, p == 0);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/trcl_pkg.sv
rtl/traction_current_ramp_limiter.sv
test/tb_traction_current_ramp_limiter.sv
